### src/pmf_pkg.sv
// Shared types, constants and the microprogram of the pose motion filter.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package pmf_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int TIME_BITS_DEF     = 48;
  localparam int QUAT_BITS_DEF     = 16;

  localparam int MAX_TIME_W  = 48;
  localparam int MAX_DIST_W  = 52;
  localparam int ANGLE_K_W   = 32;
  localparam int CFG_DATA_W  = 52;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TIME = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DIST = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_K  = 2'd2;

  localparam logic [ANGLE_K_W-1:0] ANGLE_UNLIMITED = '1;

  // tan^2 limit is Q8.24
  localparam int ANGLE_FRAC_BITS = 24;

  localparam int PC_W       = 5;
  localparam int UCODE_LEN  = 30;
  localparam logic [PC_W-1:0] PC_FIN = PC_W'(UCODE_LEN - 1);

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_DX, SRC_DY, SRC_DZ,
    SRC_QW, SRC_QX, SRC_QY, SRC_QZ,
    SRC_RW, SRC_RX, SRC_RY, SRC_RZ,
    SRC_MW, SRC_MX, SRC_MY, SRC_MZ,
    SRC_K, SRC_WLO, SRC_WHI
  } src_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [3:0] {
    ST_NONE, ST_DIST, ST_CW, ST_CX, ST_CY, ST_CZ, ST_VSQ, ST_WSQ, ST_ANGLE
  } store_t;

  typedef enum logic [1:0] {
    JMP_NONE, JMP_SKIP, JMP_FIN
  } jump_t;

  typedef struct packed {
    src_t             src_a;
    src_t             src_b;
    acc_op_t          acc_op;
    store_t           store;
    jump_t            jump;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic   load;
    logic   run;
    logic   fin;
    uword_t word;
  } ctl_t;

  typedef struct packed {
    logic skip;
    logic similar;
  } dp_status_t;

  function automatic uword_t mk(src_t a, src_t b, acc_op_t op, store_t st, jump_t j);
    uword_t w;
    w.src_a  = a;
    w.src_b  = b;
    w.acc_op = op;
    w.store  = st;
    w.jump   = j;
    w.target = PC_FIN;
    return w;
  endfunction

  // Multiply issues in a step; the accumulator consumes that product in the next step.
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:  w = mk(SRC_DX,   SRC_DX,   ACC_HOLD,   ST_NONE,  JMP_NONE);
      5'd1:  w = mk(SRC_DY,   SRC_DY,   ACC_LOAD,   ST_NONE,  JMP_NONE);
      5'd2:  w = mk(SRC_DZ,   SRC_DZ,   ACC_ADD,    ST_NONE,  JMP_NONE);
      5'd3:  w = mk(SRC_QW,   SRC_RW,   ACC_ADD,    ST_NONE,  JMP_NONE);
      5'd4:  w = mk(SRC_QX,   SRC_RX,   ACC_LOAD,   ST_DIST,  JMP_NONE);
      5'd5:  w = mk(SRC_QY,   SRC_RY,   ACC_ADD,    ST_NONE,  JMP_SKIP);
      5'd6:  w = mk(SRC_QZ,   SRC_RZ,   ACC_ADD,    ST_NONE,  JMP_NONE);
      5'd7:  w = mk(SRC_QW,   SRC_RX,   ACC_ADD,    ST_NONE,  JMP_NONE);
      5'd8:  w = mk(SRC_RW,   SRC_QX,   ACC_LOAD,   ST_CW,    JMP_NONE);
      5'd9:  w = mk(SRC_QY,   SRC_RZ,   ACC_SUB,    ST_NONE,  JMP_NONE);
      5'd10: w = mk(SRC_QZ,   SRC_RY,   ACC_SUB,    ST_NONE,  JMP_NONE);
      5'd11: w = mk(SRC_QW,   SRC_RY,   ACC_ADD,    ST_NONE,  JMP_NONE);
      5'd12: w = mk(SRC_RW,   SRC_QY,   ACC_LOAD,   ST_CX,    JMP_NONE);
      5'd13: w = mk(SRC_QZ,   SRC_RX,   ACC_SUB,    ST_NONE,  JMP_NONE);
      5'd14: w = mk(SRC_QX,   SRC_RZ,   ACC_SUB,    ST_NONE,  JMP_NONE);
      5'd15: w = mk(SRC_QW,   SRC_RZ,   ACC_ADD,    ST_NONE,  JMP_NONE);
      5'd16: w = mk(SRC_RW,   SRC_QZ,   ACC_LOAD,   ST_CY,    JMP_NONE);
      5'd17: w = mk(SRC_QX,   SRC_RY,   ACC_SUB,    ST_NONE,  JMP_NONE);
      5'd18: w = mk(SRC_QY,   SRC_RX,   ACC_SUB,    ST_NONE,  JMP_NONE);
      5'd19: w = mk(SRC_MX,   SRC_MX,   ACC_ADD,    ST_NONE,  JMP_NONE);
      5'd20: w = mk(SRC_MY,   SRC_MY,   ACC_LOAD,   ST_CZ,    JMP_NONE);
      5'd21: w = mk(SRC_MZ,   SRC_MZ,   ACC_ADD,    ST_NONE,  JMP_NONE);
      5'd22: w = mk(SRC_MW,   SRC_MW,   ACC_ADD,    ST_NONE,  JMP_NONE);
      5'd23: w = mk(SRC_ZERO, SRC_ZERO, ACC_LOAD,   ST_VSQ,   JMP_NONE);
      5'd24: w = mk(SRC_ZERO, SRC_ZERO, ACC_HOLD,   ST_WSQ,   JMP_NONE);
      5'd25: w = mk(SRC_K,    SRC_WLO,  ACC_HOLD,   ST_NONE,  JMP_NONE);
      5'd26: w = mk(SRC_K,    SRC_WHI,  ACC_LOAD,   ST_NONE,  JMP_NONE);
      5'd27: w = mk(SRC_ZERO, SRC_ZERO, ACC_ADD_HI, ST_NONE,  JMP_NONE);
      5'd28: w = mk(SRC_ZERO, SRC_ZERO, ACC_HOLD,   ST_ANGLE, JMP_NONE);
      5'd29: w = mk(SRC_ZERO, SRC_ZERO, ACC_HOLD,   ST_NONE,  JMP_FIN);
      default: w = mk(SRC_ZERO, SRC_ZERO, ACC_HOLD, ST_NONE,  JMP_FIN);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### src/pose_motion_filter_core.sv
// Top level of the pose motion filter: configuration registers, result register,
// sequencer and datapath. Depends on pmf_pkg, pmf_sequencer, pmf_datapath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  pose     | pose_valid / pose_stall   | timestamp, pos_x/y/z, quat_w/x/y/z
//  result   | result_valid/result_stall | similar
//  config   | cfg_write                 | cfg_index, cfg_data
//
// A pose transfer starts the 30-step microprogram on one shared multiplier. result_valid
// rises at the end of the full program when the angle test runs, and after a jump to the
// final step when the reference, time or distance check already decides it or the angle
// is unlimited. pose_stall is high until then, so a new pose is taken only once the last
// one is finished. A waiting result does not block the next pose; only the final step
// waits while result_stall holds the previous result. rst is synchronous and clears the
// control state, the limit registers and the reference flag.
`default_nettype none

module pose_motion_filter_core #(
  parameter int POSITION_BITS = pmf_pkg::POSITION_BITS_DEF,
  parameter int TIME_BITS     = pmf_pkg::TIME_BITS_DEF,
  parameter int QUAT_BITS     = pmf_pkg::QUAT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [pmf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [pmf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                pose_valid,
  output logic                                     pose_stall,
  input  wire logic [TIME_BITS-1:0]                timestamp,
  input  wire logic signed [POSITION_BITS-1:0]     pos_x,
  input  wire logic signed [POSITION_BITS-1:0]     pos_y,
  input  wire logic signed [POSITION_BITS-1:0]     pos_z,
  input  wire logic signed [QUAT_BITS-1:0]         quat_w,
  input  wire logic signed [QUAT_BITS-1:0]         quat_x,
  input  wire logic signed [QUAT_BITS-1:0]         quat_y,
  input  wire logic signed [QUAT_BITS-1:0]         quat_z,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic                                     similar
);

  logic [pmf_pkg::MAX_TIME_W-1:0] max_time;
  logic [pmf_pkg::MAX_DIST_W-1:0] max_dist;
  logic [pmf_pkg::ANGLE_K_W-1:0]  angle_k;

  pmf_pkg::ctl_t       ctl;
  pmf_pkg::dp_status_t status;
  logic                busy;
  logic                out_blocked;

  assign pose_stall  = busy;
  assign out_blocked = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_time <= '0;
      max_dist <= '0;
      angle_k  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pmf_pkg::CFG_MAX_TIME: max_time <= cfg_data[pmf_pkg::MAX_TIME_W-1:0];
        pmf_pkg::CFG_MAX_DIST: max_dist <= cfg_data[pmf_pkg::MAX_DIST_W-1:0];
        pmf_pkg::CFG_ANGLE_K:  angle_k  <= cfg_data[pmf_pkg::ANGLE_K_W-1:0];
        default: ;
      endcase
    end
  end

  pmf_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (pose_valid),
    .out_blocked (out_blocked),
    .status      (status),
    .ctl         (ctl),
    .busy        (busy)
  );

  pmf_datapath #(
    .POSITION_BITS (POSITION_BITS),
    .TIME_BITS     (TIME_BITS),
    .QUAT_BITS     (QUAT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .max_time  (max_time),
    .max_dist  (max_dist),
    .angle_k   (angle_k),
    .timestamp (timestamp),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.fin) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) similar <= status.similar;
  end

  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    ctl.fin |=> result_valid && (similar == $past(status.similar)))
    else $error("finished pose did not reach the result register");

endmodule

`default_nettype wire

### src/pmf_sequencer.sv
// Step counter and microprogram fetch for the pose motion filter.
// Depends on pmf_pkg (control word, program table).
`default_nettype none

module pmf_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               out_blocked,
  input  wire pmf_pkg::dp_status_t status,
  output pmf_pkg::ctl_t           ctl,
  output logic                    busy
);

  logic [pmf_pkg::PC_W-1:0] pc;
  pmf_pkg::uword_t          word;
  logic                     load;
  logic                     fin;

  assign word = pmf_pkg::ucode(pc);
  assign load = start && !busy;
  assign fin  = busy && (word.jump == pmf_pkg::JMP_FIN) && !out_blocked;

  always_comb begin
    ctl.load = load;
    ctl.run  = busy;
    ctl.fin  = fin;
    ctl.word = word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (load) begin
      busy <= 1'b1;
      pc   <= '0;
    end else if (busy) begin
      case (word.jump)
        pmf_pkg::JMP_FIN: begin
          if (!out_blocked) busy <= 1'b0;
        end
        pmf_pkg::JMP_SKIP: begin
          pc <= status.skip ? word.target : pc + 1'b1;
        end
        default: begin
          pc <= pc + 1'b1;
        end
      endcase
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && (pc == '0))
    else $error("transfer did not start the program");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc < pmf_pkg::PC_W'(pmf_pkg::UCODE_LEN)))
    else $error("step counter ran past the program");

  a_fin_ends: assert property (@(posedge clk) disable iff (rst)
    fin |=> !busy)
    else $error("sequencer still busy after final step");

endmodule

`default_nettype wire

### src/pmf_datapath.sv
// Datapath: held pose, reference pose, shared multiplier, accumulator, test flags.
// Depends on pmf_pkg (control word, source and store codes).
`default_nettype none

module pmf_datapath #(
  parameter int POSITION_BITS = pmf_pkg::POSITION_BITS_DEF,
  parameter int TIME_BITS     = pmf_pkg::TIME_BITS_DEF,
  parameter int QUAT_BITS     = pmf_pkg::QUAT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pmf_pkg::ctl_t                      ctl,
  input  wire logic [pmf_pkg::MAX_TIME_W-1:0]     max_time,
  input  wire logic [pmf_pkg::MAX_DIST_W-1:0]     max_dist,
  input  wire logic [pmf_pkg::ANGLE_K_W-1:0]      angle_k,
  input  wire logic [TIME_BITS-1:0]               timestamp,
  input  wire logic signed [POSITION_BITS-1:0]    pos_x,
  input  wire logic signed [POSITION_BITS-1:0]    pos_y,
  input  wire logic signed [POSITION_BITS-1:0]    pos_z,
  input  wire logic signed [QUAT_BITS-1:0]        quat_w,
  input  wire logic signed [QUAT_BITS-1:0]        quat_x,
  input  wire logic signed [QUAT_BITS-1:0]        quat_y,
  input  wire logic signed [QUAT_BITS-1:0]        quat_z,
  output pmf_pkg::dp_status_t                     status
);

  localparam int DW   = POSITION_BITS + 1;
  localparam int MW   = (DW > pmf_pkg::ANGLE_K_W + 1) ? DW : pmf_pkg::ANGLE_K_W + 1;
  localparam int PW   = 2 * MW;
  localparam int AW   = (PW + 2 > 2 * QUAT_BITS + 38) ? PW + 2 : 2 * QUAT_BITS + 38;
  localparam int CW   = 2 * QUAT_BITS + 2;
  localparam int RSW  = CW + 1;
  localparam int MAGW = QUAT_BITS + 2;
  localparam int SQW  = 2 * QUAT_BITS + 4;
  localparam int TCW  = (TIME_BITS > pmf_pkg::MAX_TIME_W) ? TIME_BITS : pmf_pkg::MAX_TIME_W;
  localparam logic [RSW-1:0] RND_HALF = RSW'(1) << (QUAT_BITS - 2);

  logic [TIME_BITS-1:0]            ts_h;
  logic signed [POSITION_BITS-1:0] pos_h [3];
  logic signed [DW-1:0]            diff  [3];
  logic signed [QUAT_BITS-1:0]     q_h   [4];
  logic                            have_ref;
  logic [TIME_BITS-1:0]            ref_time;
  logic signed [POSITION_BITS-1:0] ref_pos [3];
  logic signed [QUAT_BITS-1:0]     ref_rot [4];

  logic signed [MW-1:0] opa;
  logic signed [MW-1:0] opb;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic [MAGW-1:0]      mag [4];
  logic [SQW-1:0]       vsq;
  logic [SQW-1:0]       wsq;
  logic [63:0]          wsq64;
  logic                 dist_ok;
  logic                 angle_ok;

  logic [TIME_BITS-1:0] t_diff;
  logic                 time_ok;
  logic                 unlimited;
  logic signed [CW-1:0] c_in;
  logic [CW-1:0]        c_mag;
  logic [RSW-1:0]       rnd_sum;
  logic [MAGW-1:0]      mag_rnd;
  logic signed [AW-1:0] prod_ext;

  assign t_diff    = ts_h - ref_time;
  assign time_ok   = (ts_h < ref_time) || (TCW'(t_diff) <= TCW'(max_time));
  assign unlimited = (angle_k == pmf_pkg::ANGLE_UNLIMITED);
  assign wsq64     = 64'(wsq);

  assign c_in    = acc[CW-1:0];
  assign c_mag   = c_in[CW-1] ? $unsigned(-c_in) : $unsigned(c_in);
  assign rnd_sum = RSW'(c_mag) + RND_HALF;
  assign mag_rnd = rnd_sum[QUAT_BITS-1 +: MAGW];
  assign prod_ext = AW'(prod);

  assign status.skip    = !have_ref || !time_ok || !dist_ok || unlimited;
  assign status.similar = have_ref && time_ok && dist_ok && (unlimited || angle_ok);

  function automatic logic signed [MW-1:0] pick(
    pmf_pkg::src_t s,
    logic signed [DW-1:0] dx, logic signed [DW-1:0] dy, logic signed [DW-1:0] dz,
    logic signed [QUAT_BITS-1:0] qw, logic signed [QUAT_BITS-1:0] qx,
    logic signed [QUAT_BITS-1:0] qy, logic signed [QUAT_BITS-1:0] qz,
    logic signed [QUAT_BITS-1:0] rw, logic signed [QUAT_BITS-1:0] rx,
    logic signed [QUAT_BITS-1:0] ry, logic signed [QUAT_BITS-1:0] rz,
    logic [MAGW-1:0] mw, logic [MAGW-1:0] mx, logic [MAGW-1:0] my, logic [MAGW-1:0] mz,
    logic [pmf_pkg::ANGLE_K_W-1:0] k, logic [31:0] wlo, logic [31:0] whi
  );
    logic signed [MW-1:0] v;
    case (s)
      pmf_pkg::SRC_DX:  v = MW'(dx);
      pmf_pkg::SRC_DY:  v = MW'(dy);
      pmf_pkg::SRC_DZ:  v = MW'(dz);
      pmf_pkg::SRC_QW:  v = MW'(qw);
      pmf_pkg::SRC_QX:  v = MW'(qx);
      pmf_pkg::SRC_QY:  v = MW'(qy);
      pmf_pkg::SRC_QZ:  v = MW'(qz);
      pmf_pkg::SRC_RW:  v = MW'(rw);
      pmf_pkg::SRC_RX:  v = MW'(rx);
      pmf_pkg::SRC_RY:  v = MW'(ry);
      pmf_pkg::SRC_RZ:  v = MW'(rz);
      pmf_pkg::SRC_MW:  v = $signed(MW'(mw));
      pmf_pkg::SRC_MX:  v = $signed(MW'(mx));
      pmf_pkg::SRC_MY:  v = $signed(MW'(my));
      pmf_pkg::SRC_MZ:  v = $signed(MW'(mz));
      pmf_pkg::SRC_K:   v = $signed(MW'(k));
      pmf_pkg::SRC_WLO: v = $signed(MW'(wlo));
      pmf_pkg::SRC_WHI: v = $signed(MW'(whi));
      default:          v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(ctl.word.src_a, diff[0], diff[1], diff[2],
               q_h[0], q_h[1], q_h[2], q_h[3], ref_rot[0], ref_rot[1], ref_rot[2], ref_rot[3],
               mag[0], mag[1], mag[2], mag[3], angle_k, wsq64[31:0], wsq64[63:32]);
    opb = pick(ctl.word.src_b, diff[0], diff[1], diff[2],
               q_h[0], q_h[1], q_h[2], q_h[3], ref_rot[0], ref_rot[1], ref_rot[2], ref_rot[3],
               mag[0], mag[1], mag[2], mag[3], angle_k, wsq64[31:0], wsq64[63:32]);
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    if (ctl.load) begin
      ts_h     <= timestamp;
      pos_h[0] <= pos_x;
      pos_h[1] <= pos_y;
      pos_h[2] <= pos_z;
      diff[0]  <= DW'(pos_x) - DW'(ref_pos[0]);
      diff[1]  <= DW'(pos_y) - DW'(ref_pos[1]);
      diff[2]  <= DW'(pos_z) - DW'(ref_pos[2]);
      q_h[0]   <= quat_w;
      q_h[1]   <= quat_x;
      q_h[2]   <= quat_y;
      q_h[3]   <= quat_z;
    end
    if (ctl.run) begin
      case (ctl.word.acc_op)
        pmf_pkg::ACC_LOAD:   acc <= prod_ext;
        pmf_pkg::ACC_ADD:    acc <= acc + prod_ext;
        pmf_pkg::ACC_SUB:    acc <= acc - prod_ext;
        pmf_pkg::ACC_ADD_HI: acc <= acc + (prod_ext <<< 32);
        default:             acc <= acc;
      endcase
      case (ctl.word.store)
        pmf_pkg::ST_DIST:  dist_ok  <= $unsigned(acc) <= AW'(max_dist);
        pmf_pkg::ST_CW:    mag[0]   <= mag_rnd;
        pmf_pkg::ST_CX:    mag[1]   <= mag_rnd;
        pmf_pkg::ST_CY:    mag[2]   <= mag_rnd;
        pmf_pkg::ST_CZ:    mag[3]   <= mag_rnd;
        pmf_pkg::ST_VSQ:   vsq      <= acc[SQW-1:0];
        pmf_pkg::ST_WSQ:   wsq      <= acc[SQW-1:0];
        pmf_pkg::ST_ANGLE: angle_ok <=
          AW'({vsq, {pmf_pkg::ANGLE_FRAC_BITS{1'b0}}}) <= $unsigned(acc);
        default: ;
      endcase
    end
    if (ctl.fin && !status.similar) begin
      ref_time <= ts_h;
      ref_pos  <= pos_h;
      ref_rot  <= q_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_ref <= 1'b0;
    end else if (ctl.fin && !status.similar) begin
      have_ref <= 1'b1;
    end
  end

  a_fin_sets_ref: assert property (@(posedge clk) disable iff (rst)
    ctl.fin |=> have_ref)
    else $error("reference not held after a finished pose");

  a_no_ref_not_similar: assert property (@(posedge clk) disable iff (rst)
    (ctl.fin && !have_ref) |-> !status.similar)
    else $error("first pose reported as similar");

endmodule

`default_nettype wire

### bench/pose_motion_filter_checker.sv
// Scoreboard for the pose motion filter: mirrors the limit registers and the reference pose,
// predicts the similar flag of every pose transfer and compares it with each result transfer.
// Depends on pmf_pkg for register indexes, widths and the unlimited angle code.
module pose_motion_filter_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pmf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pmf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                pose_valid,
  input  logic                                pose_stall,
  input  logic [pmf_pkg::TIME_BITS_DEF-1:0]   timestamp,
  input  logic signed [pmf_pkg::POSITION_BITS_DEF-1:0] pos_x,
  input  logic signed [pmf_pkg::POSITION_BITS_DEF-1:0] pos_y,
  input  logic signed [pmf_pkg::POSITION_BITS_DEF-1:0] pos_z,
  input  logic signed [pmf_pkg::QUAT_BITS_DEF-1:0]     quat_w,
  input  logic signed [pmf_pkg::QUAT_BITS_DEF-1:0]     quat_x,
  input  logic signed [pmf_pkg::QUAT_BITS_DEF-1:0]     quat_y,
  input  logic signed [pmf_pkg::QUAT_BITS_DEF-1:0]     quat_z,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  logic                                similar,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  checked,
  output int                                  similar_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = pmf_pkg::TIME_BITS_DEF;
  localparam int PW = pmf_pkg::POSITION_BITS_DEF;
  localparam int QW = pmf_pkg::QUAT_BITS_DEF;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } rotation_t;

  logic [TW-1:0]                max_time;
  logic [pmf_pkg::MAX_DIST_W-1:0] max_dist;
  logic [pmf_pkg::ANGLE_K_W-1:0]  angle_k;

  bit                   have_ref;
  logic [TW-1:0]        ref_time;
  logic signed [PW-1:0] ref_px, ref_py, ref_pz;
  rotation_t            ref_rot;

  bit expected_similar_q[$];

  function automatic logic [63:0] rounded_mag(longint c);
    logic [63:0] m;
    m = (c < 0) ? 64'(-c) : 64'(c);
    return (m + (64'd1 << (QW - 2))) >> (QW - 1);
  endfunction

  function automatic logic [63:0] square_gap(longint a, longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return 64'(d) * 64'(d);
  endfunction

  // conj(q) * r, components rounded, then |v|^2 * 2^24 <= k * w^2
  function automatic bit rotation_within(rotation_t q, rotation_t r);
    longint qw, qx, qy, qz, rw, rx, ry, rz, cw, cx, cy, cz;
    logic [63:0] mw, mx, my, mz, vsq, wsq;
    logic [127:0] lhs, rhs, kk, ww;
    if (angle_k == pmf_pkg::ANGLE_UNLIMITED) return 1'b1;
    qw = $signed(q.w); qx = $signed(q.x); qy = $signed(q.y); qz = $signed(q.z);
    rw = $signed(r.w); rx = $signed(r.x); ry = $signed(r.y); rz = $signed(r.z);
    cw = qw * rw + qx * rx + qy * ry + qz * rz;
    cx = qw * rx - rw * qx - (qy * rz - qz * ry);
    cy = qw * ry - rw * qy - (qz * rx - qx * rz);
    cz = qw * rz - rw * qz - (qx * ry - qy * rx);
    mw = rounded_mag(cw);
    mx = rounded_mag(cx);
    my = rounded_mag(cy);
    mz = rounded_mag(cz);
    vsq = mx * mx + my * my + mz * mz;
    wsq = mw * mw;
    kk = 128'(angle_k);
    ww = 128'(wsq);
    rhs = kk * ww;
    lhs = 128'(vsq) << pmf_pkg::ANGLE_FRAC_BITS;
    return lhs <= rhs;
  endfunction

  task automatic judge_pose(output bit is_similar);
    logic [63:0] sum, s;
    logic [64:0] t;
    bit time_ok, dist_ok;
    rotation_t rot;
    rot = '{w: quat_w, x: quat_x, y: quat_y, z: quat_z};
    time_ok = (timestamp < ref_time) || ((timestamp - ref_time) <= max_time);
    sum = square_gap($signed(pos_x), $signed(ref_px));
    s = square_gap($signed(pos_y), $signed(ref_py));
    t = {1'b0, sum} + s;
    sum = t[64] ? '1 : t[63:0];
    s = square_gap($signed(pos_z), $signed(ref_pz));
    t = {1'b0, sum} + s;
    sum = t[64] ? '1 : t[63:0];
    dist_ok = sum <= 64'(max_dist);
    if (have_ref && time_ok && dist_ok && rotation_within(rot, ref_rot)) begin
      is_similar = 1'b1;
    end else begin
      is_similar = 1'b0;
      have_ref = 1'b1;
      ref_time = timestamp;
      ref_px = pos_x;
      ref_py = pos_y;
      ref_pz = pos_z;
      ref_rot = rot;
    end
  endtask

  always @(posedge clk) begin : watch
    bit want;
    bit got;
    if (rst) begin
      max_time = '0;
      max_dist = '0;
      angle_k = '0;
      have_ref = 1'b0;
      ref_time = '0;
      ref_px = '0;
      ref_py = '0;
      ref_pz = '0;
      ref_rot = '0;
      expected_similar_q.delete();
      mismatches = 0;
      pending = 0;
      checked = 0;
      similar_seen = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          pmf_pkg::CFG_MAX_TIME: max_time = cfg_data[TW-1:0];
          pmf_pkg::CFG_MAX_DIST: max_dist = cfg_data[pmf_pkg::MAX_DIST_W-1:0];
          pmf_pkg::CFG_ANGLE_K:  angle_k = cfg_data[pmf_pkg::ANGLE_K_W-1:0];
          default: ;
        endcase
      end
      // older result first: a result never belongs to a pose taken at the same edge
      if (result_valid && !result_stall) begin
        if (expected_similar_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no pose pending, expected none actual %0b",
                   $time, similar);
        end else begin
          want = expected_similar_q.pop_front();
          checked++;
          if (similar === 1'b1) similar_seen++;
          if (similar !== want) begin
            mismatches++;
            $display("%0t: similar mismatch, expected %0b actual %0b", $time, want, similar);
          end
        end
      end
      if (pose_valid && !pose_stall) begin
        judge_pose(got);
        expected_similar_q.push_back(got);
      end
      pending = expected_similar_q.size();
    end
  end

endmodule

### bench/pose_motion_filter_core_tb.sv
// Testbench top for pose_motion_filter_core: clock, reset, limit register writes and pose
// stimulus with random idling on both channels. Depends on pmf_pkg and the checker module.
module pose_motion_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = pmf_pkg::TIME_BITS_DEF;
  localparam int PW = pmf_pkg::POSITION_BITS_DEF;
  localparam int QW = pmf_pkg::QUAT_BITS_DEF;
  localparam int DW = pmf_pkg::CFG_DATA_W;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 50;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 40;
  localparam int CYCLE_LIMIT = 250000;
  localparam int POS_HALF = 1 << (PW - 1);
  localparam int ROT_HALF = 1 << (QW - 1);
  localparam logic [pmf_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [TW-1:0] TIME_FULL = '1;
  localparam logic [pmf_pkg::MAX_DIST_W-1:0] DIST_FULL = '1;
  localparam logic [pmf_pkg::ANGLE_K_W-1:0] K_TEN_DEG = 32'd521000;

  logic clk, rst;
  logic cfg_write;
  logic [pmf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [DW-1:0] cfg_data;
  logic pose_valid, pose_stall;
  logic [TW-1:0] timestamp;
  logic signed [PW-1:0] pos_x, pos_y, pos_z;
  logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
  logic result_valid, result_stall, similar;

  int mismatches, pending, checked, similar_seen;
  int cycle_count, poses_sent, settings_used, idle_pct;
  bit quiet, long_hold_req;

  int anchor_px, anchor_py, anchor_pz;
  int anchor_qw, anchor_qx, anchor_qy, anchor_qz;
  logic [TW-1:0] cur_ts;
  int tstep, pspread, qspread;

  pose_motion_filter_core uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pose_valid(pose_valid), .pose_stall(pose_stall), .timestamp(timestamp),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .result_valid(result_valid), .result_stall(result_stall), .similar(similar)
  );

  pose_motion_filter_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pose_valid(pose_valid), .pose_stall(pose_stall), .timestamp(timestamp),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .result_valid(result_valid), .result_stall(result_stall), .similar(similar),
    .mismatches(mismatches), .pending(pending), .checked(checked),
    .similar_seen(similar_seen)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall bursts, one long hold on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && !quiet && $urandom_range(0, 99) < idle_pct) begin
        hold_left = $urandom_range(1, 9);
      end
      result_stall = (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  function automatic int jitter(int base, int spread, int half);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < -half) v = -half;
    if (v > half - 1) v = half - 1;
    return v;
  endfunction

  task automatic write_reg(input logic [pmf_pkg::CFG_INDEX_W-1:0] idx, input logic [DW-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    pose_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_limits(input logic [TW-1:0] mt, input logic [pmf_pkg::MAX_DIST_W-1:0] md,
                            input logic [pmf_pkg::ANGLE_K_W-1:0] k);
    logic [DW-1:0] junk;
    drain_results();
    junk = DW'({$urandom, $urandom});
    write_reg(pmf_pkg::CFG_MAX_TIME, {junk[DW-1:TW], mt});
    write_reg(pmf_pkg::CFG_MAX_DIST, md);
    junk = DW'({$urandom, $urandom});
    write_reg(pmf_pkg::CFG_ANGLE_K, {junk[DW-1:pmf_pkg::ANGLE_K_W], k});
    write_reg(CFG_SPARE, DW'({$urandom, $urandom}));
    settings_used++;
  endtask

  task automatic send_pose(input logic [TW-1:0] ts,
                           input logic signed [PW-1:0] px, py, pz,
                           input logic signed [QW-1:0] qw, qx, qy, qz);
    @(negedge clk);
    timestamp = ts;
    pos_x = px;
    pos_y = py;
    pos_z = pz;
    quat_w = qw;
    quat_x = qx;
    quat_y = qy;
    quat_z = qz;
    pose_valid = 1'b1;
    do @(posedge clk); while (pose_stall);
    poses_sent++;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      pose_valid = 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk);
    end
  endtask

  task automatic new_anchor();
    anchor_px = int'($urandom_range(0, 2 * POS_HALF - 1)) - POS_HALF;
    anchor_py = int'($urandom_range(0, 2 * POS_HALF - 1)) - POS_HALF;
    anchor_pz = int'($urandom_range(0, 2 * POS_HALF - 1)) - POS_HALF;
    if ($urandom_range(0, 7) == 0) begin
      anchor_qw = int'($urandom_range(0, 2 * ROT_HALF - 1)) - ROT_HALF;
      anchor_qx = int'($urandom_range(0, 2 * ROT_HALF - 1)) - ROT_HALF;
      anchor_qy = int'($urandom_range(0, 2 * ROT_HALF - 1)) - ROT_HALF;
      anchor_qz = int'($urandom_range(0, 2 * ROT_HALF - 1)) - ROT_HALF;
    end else begin
      anchor_qw = int'($urandom_range(16000, ROT_HALF - 1));
      if ($urandom_range(0, 1) == 1) anchor_qw = -anchor_qw;
      anchor_qx = int'($urandom_range(0, 24000)) - 12000;
      anchor_qy = int'($urandom_range(0, 24000)) - 12000;
      anchor_qz = int'($urandom_range(0, 24000)) - 12000;
    end
    if ($urandom_range(0, 3) == 0) cur_ts = TW'({$urandom, $urandom});
  endtask

  initial begin : stimulus
    logic [TW-1:0] mt;
    logic [pmf_pkg::MAX_DIST_W-1:0] md;
    logic [pmf_pkg::ANGLE_K_W-1:0] k;
    int roll;
    int p;
    int i;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pose_valid = 1'b0;
    timestamp = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    quat_w = '0;
    quat_x = '0;
    quat_y = '0;
    quat_z = '0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    idle_pct = 20;
    poses_sent = 0;
    settings_used = 0;
    cur_ts = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: time, distance and angle boundaries
    set_limits(48'd1000, 52'd100, K_TEN_DEG);
    send_pose(48'd5000, 24'sd0, 24'sd0, 24'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd5000, 24'sd0, 24'sd0, 24'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd4000, 24'sd0, 24'sd0, 24'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd6000, 24'sd0, 24'sd0, 24'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd6001, 24'sd0, 24'sd0, 24'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd6001, 24'sd6, 24'sd8, 24'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd6001, 24'sd6, 24'sd8, 24'sd1, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd6001, 24'sd6, 24'sd8, 24'sd1, 16'sd32767, 16'sd1000, 16'sd0, 16'sd0);
    send_pose(48'd6001, 24'sd6, 24'sd8, 24'sd1, 16'sd23170, 16'sd23170, 16'sd0, 16'sd0);
    send_pose(48'd6001, 24'sd6, 24'sd8, 24'sd1, -16'sd23170, -16'sd23170, 16'sd0, 16'sd0);
    set_limits(48'd1000, 52'd100, '0);
    send_pose(48'd6002, 24'sd6, 24'sd8, 24'sd1, 16'sd23170, 16'sd23170, 16'sd0, 16'sd0);
    send_pose(48'd6002, 24'sd6, 24'sd8, 24'sd1, 16'sd23170, 16'sd23100, 16'sd50, 16'sd0);
    // zero quaternions
    send_pose(48'd6002, 24'sd6, 24'sd8, 24'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd6003, 24'sd1000, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd6003, 24'sd1000, 24'sd0, 24'sd0,
              16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    // rotation with w rounding to zero
    set_limits(48'd1000, 52'd100, pmf_pkg::ANGLE_UNLIMITED - 1);
    send_pose(48'd7000, 24'sd0, 24'sd2000, 24'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd7000, 24'sd0, 24'sd2000, 24'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0);
    set_limits(TIME_FULL, DIST_FULL, pmf_pkg::ANGLE_UNLIMITED);
    send_pose(48'd7001, 24'sd0, 24'sd2000, 24'sd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pose(TIME_FULL, 24'h800000, 24'h800000, 24'h800000,
              16'sd12, 16'h7FFF, 16'h8000, 16'sd5);
    send_pose(TIME_FULL, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
              16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    set_limits('0, '0, '0);
    send_pose(48'd0, 24'h7FFFFF, 24'h800000, 24'sd3, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd0, 24'h7FFFFF, 24'h800000, 24'sd3, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_pose(48'd1, 24'h7FFFFF, 24'h800000, 24'sd3, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);

    // random phases of near-reference pose streams with noise
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: begin
          mt = TIME_FULL;
          md = DIST_FULL;
          k = pmf_pkg::ANGLE_UNLIMITED;
        end
        2: begin
          mt = '0;
          md = '0;
          k = '0;
        end
        3: begin
          mt = TW'($urandom_range(0, 4000));
          md = pmf_pkg::MAX_DIST_W'($urandom_range(0, 300000));
          k = pmf_pkg::ANGLE_UNLIMITED - 1;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) mt = TW'({$urandom, $urandom});
          else mt = TW'($urandom_range(0, 4000));
          if ($urandom_range(0, 5) == 0) md = pmf_pkg::MAX_DIST_W'({$urandom, $urandom});
          else md = pmf_pkg::MAX_DIST_W'($urandom_range(0, 300000));
          if ($urandom_range(0, 1) == 0) k = $urandom_range(0, 1 << 23);
          else k = $urandom;
        end
      endcase
      set_limits(mt, md, k);
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      idle_pct = (p % 3 == 0) ? 0 : 30;
      tstep = $urandom_range(0, 1500);
      case ($urandom_range(0, 3))
        0: pspread = 2;
        1: pspread = 50;
        2: pspread = 200;
        default: pspread = 400;
      endcase
      case ($urandom_range(0, 3))
        0: qspread = 0;
        1: qspread = 30;
        2: qspread = 300;
        default: qspread = 3000;
      endcase
      new_anchor();
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == 5) long_hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 4) new_anchor();
        if (roll < 10) begin
          send_pose(TW'({$urandom, $urandom}), PW'($urandom), PW'($urandom), PW'($urandom),
                    QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
        end else begin
          if ($urandom_range(0, 19) == 0) cur_ts = cur_ts - TW'($urandom_range(0, 3000));
          else cur_ts = cur_ts + TW'($urandom_range(0, tstep));
          if (roll < 16)
            send_pose(cur_ts + TW'($urandom_range(0, 1 << 20)),
                      PW'(jitter(anchor_px, 100000, POS_HALF)),
                      PW'(jitter(anchor_py, 100000, POS_HALF)),
                      PW'(jitter(anchor_pz, 100000, POS_HALF)),
                      QW'(jitter(anchor_qw, 8000, ROT_HALF)),
                      QW'(jitter(anchor_qx, 8000, ROT_HALF)),
                      QW'(jitter(anchor_qy, 8000, ROT_HALF)),
                      QW'(jitter(anchor_qz, 8000, ROT_HALF)));
          else
            send_pose(cur_ts,
                      PW'(jitter(anchor_px, pspread, POS_HALF)),
                      PW'(jitter(anchor_py, pspread, POS_HALF)),
                      PW'(jitter(anchor_pz, pspread, POS_HALF)),
                      QW'(jitter(anchor_qw, qspread, ROT_HALF)),
                      QW'(jitter(anchor_qx, qspread, ROT_HALF)),
                      QW'(jitter(anchor_qy, qspread, ROT_HALF)),
                      QW'(jitter(anchor_qz, qspread, ROT_HALF)));
        end
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    $display("%0d poses over %0d limit settings, incl. a %0d-cycle result hold-off",
             poses_sent, settings_used, LONG_HOLD);
    $display("%0d results checked, %0d reported similar, %0d mismatches",
             checked, similar_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
